// ===== hdl/cpts_pkg.sv =====
`default_nettype none
package cpts_pkg;
  localparam int TASK_SLOTS = 64;
  localparam int SLOT_W = 6;
  localparam int ENTRY_W = 1 + 3 + 8 + 7 + 32 + 1 + 1;

  localparam logic [2:0] FN_TICK = 3'd0;
  localparam logic [2:0] FN_SETSTATE = 3'd1;
  localparam logic [2:0] FN_LOAD = 3'd2;
  localparam logic [2:0] FN_WAKE = 3'd3;
  localparam logic [2:0] FN_SIGNAL = 3'd4;
  localparam logic [2:0] FN_ALARM = 3'd5;

  localparam logic [2:0] RS_RUNNING = 3'd0;
  localparam logic [2:0] RS_SLEEPING = 3'd1;

  typedef struct packed {
    logic        present;
    logic [2:0]  run_state;
    logic [7:0]  counter;
    logic [6:0]  prio;
    logic [31:0] deadline;
    logic        pending;
    logic        intr;
  } entry_t;
endpackage
`default_nettype wire

// ===== hdl/counter_priority_task_scheduler.sv =====
`default_nettype none
// Counter-priority task scheduler over a table of 64 task slots held in one
// single-port-read RAM. After reset a clearing pass writes every slot, one per
// cycle, before the first item is taken. Load, wake, signal and unused items
// need only one slot access; alarm items also run a 32-step restoring divide
// for the seconds left when an old alarm is still ahead. Tick and set-state
// items run a schedule pass: one read-modify-write sweep over slots 63 down
// to 1 for alarms and wakeups, one pick sweep, and when the best counter is
// zero a recompute sweep and a second pick; each slot visit in a sweep has a
// read state and then a modify or check state, for the RAM read latency and
// the write back. Only one item is in flight; the input waits for the result.
module counter_priority_task_scheduler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [15:0]                 cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  func,
  input  wire logic [cpts_pkg::SLOT_W-1:0] slot,
  input  wire logic [31:0]                 now,
  input  wire logic [2:0]                  new_state,
  input  wire logic [6:0]                  priority_value,
  input  wire logic                        flag_value,
  input  wire logic [15:0]                 seconds,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cpts_pkg::SLOT_W-1:0]      running_slot,
  output logic                             was_interrupted,
  output logic [15:0]                      alarm_left
);
  import cpts_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_RD1    = 11'b00000000100,
    S_MOD1   = 11'b00000001000,
    S_SWRD   = 11'b00000010000,
    S_SWMOD  = 11'b00000100000,
    S_PKRD   = 11'b00001000000,
    S_PKCHK  = 11'b00010000000,
    S_FIN    = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  // sweep kinds
  localparam logic [1:0] SW_ALARM = 2'd0;
  localparam logic [1:0] SW_RECALC = 2'd1;

  state_t state;
  logic [15:0] tps;
  logic [2:0] f_r;
  logic [SLOT_W-1:0] slot_r, cur, idx, best_slot;
  logic [31:0] now_r;
  logic [2:0] ns_r;
  logic [6:0] prio_r;
  logic flag_r;
  logic [15:0] secs_r;
  logic [1:0] kind;
  logic second_pick;
  logic best_any;
  logic [7:0] best_cnt;
  logic [31:0] rem, quo, dvd;
  logic [5:0] dcnt;
  logic [31:0] span;

  logic we;
  logic [SLOT_W-1:0] waddr, raddr;
  entry_t wdata, rd;
  logic [ENTRY_W-1:0] rdata;
  assign rd = entry_t'(rdata);

  cpts_ram #(.WIDTH(ENTRY_W), .DEPTH(TASK_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ENTRY_W'(wdata)),
    .raddr(raddr), .rdata(rdata)
  );

  logic [15:0] rate;
  assign rate = (tps == 16'd0) ? 16'd1 : tps;
  logic [32:0] trial;
  assign trial = {rem, dvd[31]} - {17'd0, rate};
  logic [8:0] recalc;
  assign recalc = {2'b0, rd.counter[7:1]} + {2'b0, rd.prio};

  assign in_ready = (state == S_IDLE) && !out_valid;

  // true when the finished pick has a best counter of zero
  function automatic logic best_any_n(entry_t e, logic any, logic [7:0] bc,
                                      logic [SLOT_W-1:0] i);
    logic hit;
    hit = e.present && e.run_state == RS_RUNNING && (i != '0);
    if (hit && (!any || e.counter > bc)) return e.counter == 8'd0;
    return any && bc == 8'd0;
  endfunction

  always_comb begin
    entry_t e;
    e = rd;
    we = 1'b0;
    waddr = idx;
    wdata = rd;
    raddr = idx;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        e = '0;
        e.present = (idx == '0);
        wdata = e;
      end
      S_IDLE: begin
        raddr = (func == FN_LOAD || func == FN_WAKE || func == FN_SIGNAL) ? slot : cur;
      end
      S_RD1: begin
        raddr = (f_r == FN_LOAD || f_r == FN_WAKE || f_r == FN_SIGNAL) ? slot_r : cur;
      end
      S_MOD1: begin
        we = 1'b1;
        case (f_r)
          FN_TICK: if (e.counter != 8'd0) e.counter = e.counter - 8'd1;
          FN_SETSTATE: e.run_state = ns_r;
          FN_LOAD: begin
            we = (slot_r != '0);
            e = '0;
            e.present = flag_r;
            e.prio = prio_r;
          end
          FN_WAKE: if (e.present && e.run_state == RS_SLEEPING)
            e.run_state = RS_RUNNING;
          FN_SIGNAL: e.pending = flag_r;
          FN_ALARM: e.deadline = (secs_r == 16'd0) ? 32'd0 : now_r + span;
          default: we = 1'b0;
        endcase
        waddr = (f_r == FN_LOAD || f_r == FN_WAKE || f_r == FN_SIGNAL) ? slot_r : cur;
        wdata = e;
      end
      S_SWMOD: begin
        we = rd.present;
        if (kind == SW_ALARM) begin
          if (e.deadline != 32'd0 && e.deadline < now_r) begin
            e.pending = 1'b1;
            e.deadline = 32'd0;
          end
          if (e.run_state == RS_SLEEPING && e.pending) begin
            e.run_state = RS_RUNNING;
            e.intr = 1'b1;
          end
        end else begin
          e.counter = recalc[8] ? 8'hff : recalc[7:0];
        end
        wdata = e;
      end
      S_FIN: begin
        we = (idx == best_slot);
        waddr = best_slot;
        raddr = best_slot;
        e.intr = 1'b0;
        wdata = e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      cur <= '0;
      tps <= 16'd100;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) tps <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          idx <= idx + SLOT_W'(1);
          if (idx == SLOT_W'(TASK_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            f_r <= func; slot_r <= slot; now_r <= now; ns_r <= new_state;
            prio_r <= priority_value; flag_r <= flag_value; secs_r <= seconds;
            span <= 32'(rate) * 32'(seconds);
            was_interrupted <= 1'b0;
            alarm_left <= 16'd0;
            quo <= '0;
            state <= S_RD1;
          end
        end
        S_RD1: state <= S_MOD1;
        S_MOD1: begin
          if (f_r == FN_TICK || f_r == FN_SETSTATE) begin
            kind <= SW_ALARM;
            idx <= SLOT_W'(TASK_SLOTS - 1);
            second_pick <= 1'b0;
            state <= S_SWRD;
          end else if (f_r == FN_ALARM && rd.deadline != 32'd0 && rd.deadline > now_r) begin
            dvd <= rd.deadline - now_r;
            rem <= '0;
            quo <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          dvd <= {dvd[30:0], 1'b0};
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], dvd[31]};
            quo <= {quo[30:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) state <= S_OUT;
        end
        S_SWRD: state <= S_SWMOD;
        S_SWMOD: begin
          if (idx == SLOT_W'(1)) begin
            idx <= SLOT_W'(TASK_SLOTS - 1);
            best_any <= 1'b0;
            best_cnt <= '0;
            best_slot <= '0;
            state <= S_PKRD;
          end else begin
            idx <= idx - SLOT_W'(1);
            state <= S_SWRD;
          end
        end
        S_PKRD: state <= S_PKCHK;
        S_PKCHK: begin
          if (rd.present && rd.run_state == RS_RUNNING &&
              (!best_any || rd.counter > best_cnt)) begin
            best_any <= 1'b1;
            best_cnt <= rd.counter;
            best_slot <= idx;
          end
          if (idx == SLOT_W'(1)) begin
            if (!second_pick && best_any_n(rd, best_any, best_cnt, idx)) begin
              second_pick <= 1'b1;
              kind <= SW_RECALC;
              idx <= SLOT_W'(TASK_SLOTS - 1);
              state <= S_SWRD;
            end else begin
              state <= S_FIN;
            end
          end else begin
            idx <= idx - SLOT_W'(1);
            state <= S_PKRD;
          end
        end
        S_FIN: begin
          // rd holds the chosen slot once idx matches it
          if (idx != best_slot) begin
            idx <= best_slot;
          end else begin
            cur <= best_slot;
            was_interrupted <= rd.intr;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (f_r == FN_ALARM) alarm_left <= (quo > 32'hffff) ? 16'hffff : quo[15:0];
          running_slot <= cur;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second item accepted");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(running_slot))
    else $error("result dropped");
  a_no_clear_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid) else $error("result during clear");
`endif
endmodule
`default_nettype wire

// ===== hdl/cpts_ram.sv =====
`default_nettype none
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
